/* hw/rtl/qsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsi_pkg
// Shared types and constants for the quantized state integrator.
// ----------------------------------------------------------------------------
package qsi_pkg;

   localparam int VALUE_WIDTH = 48;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int HALF_WIDTH  = (VALUE_WIDTH + 1) / 2;
   localparam int DIV_STEPS   = VALUE_WIDTH + FRAC_BITS;
   localparam int CNT_WIDTH   = $clog2(DIV_STEPS + 1);

   localparam logic [VALUE_WIDTH-1:0] VMAX_U = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VMIN_U = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [VALUE_WIDTH-1:0]        time_type;

   typedef enum logic [1:0] {
      OP_QUANTA  = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_EVENT   = 2'd2,
      OP_OBSERVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_PHASE   = 2'd1,
      ERR_RISING  = 2'd2,
      ERR_FALLING = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_INIT        = 3'd0,
      PH_WAIT_QUANTA = 3'd1,
      PH_WAIT_SLOPE  = 3'd2,
      PH_WAIT_BOTH   = 3'd3,
      PH_RUNNING     = 3'd4
   } phase_type;

   localparam logic CSR_INITIAL_VALUE  = 1'b0;
   localparam logic CSR_OUTPUT_ENABLED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG_MUL,
      ST_SEG_ADD,
      ST_APPLY,
      ST_INT_SUM,
      ST_INT_MUL,
      ST_INT_ADD,
      ST_FINISH,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     start;
      time_type dividend;
      time_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      time_type quotient;
   } div_rsp_type;

   function automatic value_type sat_add(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
         return s[VALUE_WIDTH] ? value_type'(VMIN_U) : value_type'(VMAX_U);
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic time_type mag_of(value_type v);
      return v[VALUE_WIDTH-1] ? time_type'(-v) : time_type'(v);
   endfunction

endpackage

/* hw/rtl/qsi_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsi_req_if / qsi_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface qsi_req_if import qsi_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    operation;
   time_type  event_time;
   value_type upper_threshold;
   value_type lower_threshold;
   value_type derivative;
   modport source (output valid, operation, event_time, upper_threshold,
                   lower_threshold, derivative, input ready);
   modport sink (input valid, operation, event_time, upper_threshold,
                 lower_threshold, derivative, output ready);
endinterface

interface qsi_rsp_if import qsi_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      emitted;
   value_type result_value;
   value_type last_emitted_value;
   logic      at_last_emission;
   time_type  time_advance;
   logic      advance_infinite;
   err_type   error_code;
   modport source (output valid, emitted, result_value, last_emitted_value,
                   at_last_emission, time_advance, advance_infinite, error_code,
                   input ready);
   modport sink (input valid, emitted, result_value, last_emitted_value,
                 at_last_emission, time_advance, advance_infinite, error_code,
                 output ready);
endinterface

/* hw/rtl/qsi_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsi_divider
// Radix-2 restoring divider: (gap << FRAC_BITS) / divisor, saturated.
// ----------------------------------------------------------------------------
module qsi_divider import qsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   time_type               quo_ff, quo_in;
   time_type               den_ff, den_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   over_ff, over_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   // dividend bits feed in msb first, then FRAC_BITS zeros
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      over_in = over_ff;
      done_in = 1'b0;
      trial   = {rem_ff[VALUE_WIDTH-1:0], num_ff[VALUE_WIDTH-1]};
      diff    = trial - {1'b0, den_ff};
      if (req.start) begin
         num_in  = req.dividend;
         den_in  = req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         over_in = 1'b0;
         cnt_in  = CNT_WIDTH'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[VALUE_WIDTH-2:0], 1'b0};
         if (!diff[VALUE_WIDTH]) begin
            rem_in = diff;
            if (quo_ff[VALUE_WIDTH-1])
               over_in = 1'b1;
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            if (quo_ff[VALUE_WIDTH-1])
               over_in = 1'b1;
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      over_ff <= over_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = over_ff ? {VALUE_WIDTH{1'b1}} : quo_ff;

endmodule

/* hw/rtl/quantized_state_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_state_integrator
// Event-driven QSS1 integrator: state update, integration, time advance.
// ----------------------------------------------------------------------------
// flow: every word runs the segment multiply, then an event word goes to ST_FINISH
// while other words also integrate; a finite advance runs the 64-step divider
// occupancy: one word in flight, ready low while busy, set by the
// four-pass shared multiplier and the bit-serial divider; rsp stalls hold ST_OUT
// reset: synchronous, active high; integrator state and registers to defaults

module quantized_state_integrator import qsi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   qsi_req_if.sink       req,
   qsi_rsp_if.source     rsp,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_wdata
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   value_type init_ff, init_in;
   logic      oen_ff, oen_in;
   value_type upper_ff, upper_in, lower_ff, lower_in;
   value_type cur_ff, cur_in, exp_ff, exp_in;
   value_type lov_ff, lov_in, sum_ff, sum_in, slope_ff, slope_in;
   time_type  lot_ff, lot_in, lst_ff, lst_in;
   logic      have_ff, have_in;

   op_type    op_ff, op_in;
   time_type  t_ff, t_in;
   value_type ut_ff, ut_in, lt_ff, lt_in, dv_ff, dv_in;
   value_type acc_ff, acc_in;
   value_type seg_ff, seg_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic      sneg_ff, sneg_in;
   logic [1:0] mcnt_ff, mcnt_in;

   logic      em_ff, em_in, atl_ff, atl_in, inf_ff, inf_in;
   value_type rv_ff, rv_in, ol_ff, ol_in;
   time_type  ta_ff, ta_in;
   err_type   err_ff, err_in;

   div_req_type dreq;
   div_rsp_type drsp;

   qsi_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // shared multiplier: |t - t0| * |slope|
   logic      dt_neg;
   time_type  dt_mag;
   time_type  sl_mag;
   logic [2*HALF_WIDTH-1:0] mul_a, mul_b, pp;
   logic [HALF_WIDTH-1:0]   a_half, b_half;
   logic [PROD_WIDTH-1:0]   pp_shift;
   logic [PROD_WIDTH-FRAC_BITS-1:0] qprod;
   value_type seg_val;
   value_type sl_now;
   logic      run_now;
   value_type int_val;

   always_comb begin
      dt_neg = t_ff < lst_ff;
      dt_mag = dt_neg ? lst_ff - t_ff : t_ff - lst_ff;
      sl_mag = mag_of(slope_ff);
      // one quarter product per pass, mcnt bit 1 picks the dt half, bit 0 the slope half
      mul_a  = (2*HALF_WIDTH)'(dt_mag);
      mul_b  = (2*HALF_WIDTH)'(sl_mag);
      a_half = mcnt_ff[1] ? mul_a[2*HALF_WIDTH-1:HALF_WIDTH] : mul_a[HALF_WIDTH-1:0];
      b_half = mcnt_ff[0] ? mul_b[2*HALF_WIDTH-1:HALF_WIDTH] : mul_b[HALF_WIDTH-1:0];
      pp     = (2*HALF_WIDTH)'(a_half) * (2*HALF_WIDTH)'(b_half);
      case (mcnt_ff)
         2'd0:    pp_shift = PROD_WIDTH'(pp);
         2'd3:    pp_shift = PROD_WIDTH'(pp) << (2 * HALF_WIDTH);
         default: pp_shift = PROD_WIDTH'(pp) << HALF_WIDTH;
      endcase
      qprod  = prod_ff[PROD_WIDTH-1:FRAC_BITS];
      if (sneg_ff) begin
         if (qprod > {{(PROD_WIDTH-FRAC_BITS-VALUE_WIDTH){1'b0}}, VMIN_U})
            seg_val = value_type'(VMIN_U);
         else
            seg_val = value_type'(-qprod[VALUE_WIDTH-1:0]);
      end else begin
         if (qprod > {{(PROD_WIDTH-FRAC_BITS-VALUE_WIDTH){1'b0}}, VMAX_U})
            seg_val = value_type'(VMAX_U);
         else
            seg_val = value_type'(qprod[VALUE_WIDTH-1:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      init_in = init_ff;  oen_in = oen_ff;
      upper_in = upper_ff; lower_in = lower_ff;
      cur_in = cur_ff; exp_in = exp_ff; lov_in = lov_ff;
      sum_in = sum_ff; slope_in = slope_ff; lot_in = lot_ff; lst_in = lst_ff;
      have_in = have_ff;
      op_in = op_ff; t_in = t_ff; ut_in = ut_ff; lt_in = lt_ff; dv_in = dv_ff;
      acc_in = acc_ff; seg_in = seg_ff; prod_in = prod_ff; sneg_in = sneg_ff;
      mcnt_in = mcnt_ff;
      em_in = em_ff; atl_in = atl_ff; inf_in = inf_ff; rv_in = rv_ff;
      ol_in = ol_ff; ta_in = ta_ff; err_in = err_ff;
      dreq.start = 1'b0;
      dreq.dividend = '0;
      dreq.divisor = '0;
      sl_now = have_ff ? slope_ff : '0;
      run_now = phase_ff == PH_RUNNING;
      int_val = have_ff ? sat_add(acc_ff, seg_val) : acc_ff;

      if (csr_write) begin
         if (csr_index == CSR_INITIAL_VALUE) begin
            init_in = value_type'(csr_wdata);
            if (phase_ff == PH_INIT)
               cur_in = value_type'(csr_wdata);
         end else begin
            oen_in = csr_wdata[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in = req.operation; t_in = req.event_time;
               ut_in = req.upper_threshold; lt_in = req.lower_threshold;
               dv_in = req.derivative;
               em_in = 1'b0; atl_in = 1'b0; rv_in = '0;
               err_in = ERR_OK;
               state_in = ST_SEG_MUL;
            end
         end
         ST_SEG_MUL: begin
            // segment of the open sample up to the item time
            prod_in  = (mcnt_ff == 2'd0 ? '0 : prod_ff) + pp_shift;
            sneg_in  = dt_neg != slope_ff[VALUE_WIDTH-1];
            mcnt_in  = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) state_in = ST_SEG_ADD;
         end
         ST_SEG_ADD: begin
            seg_in   = seg_val;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_FINISH;
            case (op_ff)
               OP_QUANTA: begin
                  upper_in = ut_ff; lower_in = lt_ff;
                  if (phase_ff == PH_WAIT_QUANTA) phase_in = PH_RUNNING;
                  else if (phase_ff == PH_WAIT_BOTH) phase_in = PH_WAIT_SLOPE;
                  state_in = ST_INT_SUM;
               end
               OP_SAMPLE: begin
                  if (have_ff) sum_in = sat_add(sum_ff, seg_ff);
                  lst_in = t_ff; slope_in = dv_ff; have_in = 1'b1;
                  if (phase_ff == PH_WAIT_SLOPE) phase_in = PH_RUNNING;
                  else if (phase_ff == PH_WAIT_BOTH) phase_in = PH_WAIT_QUANTA;
                  state_in = ST_INT_SUM;
               end
               OP_EVENT: begin
                  if (phase_ff == PH_RUNNING) begin
                     em_in = oen_ff;
                     rv_in = oen_ff ? exp_ff : '0;
                     lov_in = exp_ff; lot_in = t_ff; sum_in = '0;
                     lst_in = t_ff; cur_in = exp_ff;
                     phase_in = PH_WAIT_QUANTA;
                  end else if (phase_ff == PH_INIT) begin
                     em_in = oen_ff;
                     rv_in = oen_ff ? cur_ff : '0;
                     lov_in = cur_ff; lot_in = t_ff;
                     phase_in = PH_WAIT_BOTH;
                  end else begin
                     err_in = ERR_PHASE;
                  end
               end
               default: begin
                  state_in = ST_INT_SUM;
                  atl_in = t_ff == lot_ff;
               end
            endcase
         end
         ST_INT_SUM: begin
            acc_in = sat_add(lov_ff, sum_ff);
            state_in = ST_INT_MUL;
         end
         ST_INT_MUL: begin
            prod_in  = (mcnt_ff == 2'd0 ? '0 : prod_ff) + pp_shift;
            sneg_in  = dt_neg != slope_ff[VALUE_WIDTH-1];
            mcnt_in  = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) state_in = ST_INT_ADD;
         end
         ST_INT_ADD: begin
            if (op_ff == OP_OBSERVE) begin
               rv_in = int_val;
            end else if (run_now) begin
               cur_in = int_val;
               exp_in = (sl_now == '0) ? int_val :
                        (sl_now[VALUE_WIDTH-1] ? lower_ff : upper_ff);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            ol_in = lov_ff; ta_in = '0; inf_in = 1'b1;
            state_in = ST_OUT;
            if (run_now && sl_now != '0) begin
               if (!sl_now[VALUE_WIDTH-1]) begin
                  if (upper_ff < cur_ff) begin
                     if (err_ff == ERR_OK) err_in = ERR_RISING;
                  end else begin
                     dreq.start = 1'b1;
                     dreq.dividend = time_type'(upper_ff - cur_ff);
                     dreq.divisor = mag_of(sl_now);
                     state_in = ST_DIV;
                  end
               end else begin
                  if (lower_ff > cur_ff) begin
                     if (err_ff == ERR_OK) err_in = ERR_FALLING;
                  end else begin
                     dreq.start = 1'b1;
                     dreq.dividend = time_type'(cur_ff - lower_ff);
                     dreq.divisor = mag_of(sl_now);
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               ta_in = drsp.quotient; inf_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_INIT;
         init_ff <= '0; oen_ff <= 1'b1;
         upper_ff <= '0; lower_ff <= '0; cur_ff <= '0; exp_ff <= '0;
         lov_ff <= '0; sum_ff <= '0; slope_ff <= '0;
         lot_ff <= '0; lst_ff <= '0; have_ff <= 1'b0;
         mcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         init_ff <= init_in; oen_ff <= oen_in;
         upper_ff <= upper_in; lower_ff <= lower_in; cur_ff <= cur_in;
         exp_ff <= exp_in; lov_ff <= lov_in; sum_ff <= sum_in;
         slope_ff <= slope_in; lot_ff <= lot_in; lst_ff <= lst_in;
         have_ff <= have_in;
         mcnt_ff <= mcnt_in;
      end
      op_ff <= op_in; t_ff <= t_in; ut_ff <= ut_in; lt_ff <= lt_in;
      dv_ff <= dv_in; acc_ff <= acc_in; seg_ff <= seg_in;
      prod_ff <= prod_in; sneg_ff <= sneg_in;
      em_ff <= em_in; atl_ff <= atl_in; inf_ff <= inf_in; rv_ff <= rv_in;
      ol_ff <= ol_in; ta_ff <= ta_in; err_ff <= err_in;
   end

   assign req.ready              = state_ff == ST_IDLE;
   assign rsp.valid              = state_ff == ST_OUT;
   assign rsp.emitted            = em_ff;
   assign rsp.result_value       = rv_ff;
   assign rsp.last_emitted_value = ol_ff;
   assign rsp.at_last_emission   = atl_ff;
   assign rsp.time_advance       = ta_ff;
   assign rsp.advance_infinite   = inf_ff;
   assign rsp.error_code         = err_ff;

endmodule

/* hw/rtl/qsi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsi_checker
// Port-level checks on the integrator's handshake and response words.
// ----------------------------------------------------------------------------
module qsi_checker import qsi_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_emitted,
   input logic rsp_advance_infinite,
   input logic [VALUE_WIDTH-1:0] rsp_time_advance,
   input logic [1:0] rsp_error_code
);

   // one word in flight: never ready while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_advance_infinite |-> rsp_time_advance == '0)
      else $error("infinite advance with nonzero time");

   a_err_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> rsp_advance_infinite || !rsp_emitted)
      else $error("error word with emission and finite advance");

endmodule

bind quantized_state_integrator qsi_checker u_qsi_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_emitted(rsp.emitted), .rsp_advance_infinite(rsp.advance_infinite),
   .rsp_time_advance(rsp.time_advance), .rsp_error_code(rsp.error_code)
);

/* test/integrator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integrator_checker
// Watches the request, response and register ports of the integrator. It
// keeps its own copy of the integrator state, predicts one response word per
// accepted request word, and compares each response field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module integrator_checker import qsi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_wdata,
   qsi_req_if                     req,
   qsi_rsp_if                     rsp,
   output int                     fail_count,
   output int                     pending
);

   typedef struct {
      logic      emitted;
      value_type result_value;
      value_type last_emitted_value;
      logic      at_last_emission;
      time_type  time_advance;
      logic      advance_infinite;
      err_type   error_code;
   } rsp_word_type;

   localparam value_type MAX_VAL = value_type'(VMAX_U);
   localparam value_type MIN_VAL = value_type'(VMIN_U);

   rsp_word_type expected_words[$];

   // register copies and integrator state
   value_type init_value_reg;
   logic      out_enable_reg;
   phase_type phase;
   value_type upper_level, lower_level, cur_value, exp_value;
   value_type last_out_value, segment_sum, last_slope;
   time_type  last_out_time, last_sample_time;
   logic      have_slope;

   assign pending = expected_words.size();

   function automatic value_type add_sat(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = a + b;
      if (s > MAX_VAL) return MAX_VAL;
      if (s < MIN_VAL) return MIN_VAL;
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic time_type slope_mag(value_type v);
      return v < 0 ? time_type'(-v) : time_type'(v);
   endfunction

   // integral of a slope over [t0, t1], truncated toward zero, saturated
   function automatic value_type segment_area(time_type t1, time_type t0, value_type s);
      logic                         neg;
      time_type                     dt;
      logic [2*VALUE_WIDTH-1:0]     prod;
      logic [2*VALUE_WIDTH-FRAC_BITS-1:0] q;
      neg  = (t1 < t0) ^ (s < 0);
      dt   = t1 < t0 ? t0 - t1 : t1 - t0;
      prod = {{VALUE_WIDTH{1'b0}}, dt} * {{VALUE_WIDTH{1'b0}}, slope_mag(s)};
      q    = prod >> FRAC_BITS;
      if (!neg) return q > MAX_VAL ? MAX_VAL : value_type'(q[VALUE_WIDTH-1:0]);
      if (q > {1'b1, {(VALUE_WIDTH-1){1'b0}}}) return MIN_VAL;
      return value_type'(-q[VALUE_WIDTH-1:0]);
   endfunction

   function automatic value_type integrated_at(time_type t);
      value_type v;
      v = add_sat(last_out_value, segment_sum);
      if (have_slope) v = add_sat(v, segment_area(t, last_sample_time, last_slope));
      return v;
   endfunction

   function automatic time_type gap_over_slope(logic [VALUE_WIDTH:0] gap, time_type d);
      logic [VALUE_WIDTH+FRAC_BITS:0] q;
      q = {gap, {FRAC_BITS{1'b0}}} / d;
      return q > {VALUE_WIDTH{1'b1}} ? {VALUE_WIDTH{1'b1}} : q[VALUE_WIDTH-1:0];
   endfunction

   task automatic refresh_running(time_type t);
      value_type s;
      if (phase == PH_RUNNING) begin
         cur_value = integrated_at(t);
         s = have_slope ? last_slope : '0;
         exp_value = s == 0 ? cur_value : (s > 0 ? upper_level : lower_level);
      end
   endtask

   task automatic step_integrator(op_type op, time_type t, value_type up, value_type lo,
                                  value_type der, output rsp_word_type w);
      value_type s;
      logic signed [VALUE_WIDTH:0] gap;
      w = '{emitted: 1'b0, result_value: '0, last_emitted_value: '0,
            at_last_emission: 1'b0, time_advance: '0, advance_infinite: 1'b1,
            error_code: ERR_OK};
      case (op)
         OP_QUANTA: begin
            upper_level = up;
            lower_level = lo;
            if (phase == PH_WAIT_QUANTA) phase = PH_RUNNING;
            else if (phase == PH_WAIT_BOTH) phase = PH_WAIT_SLOPE;
            refresh_running(t);
         end
         OP_SAMPLE: begin
            if (have_slope)
               segment_sum = add_sat(segment_sum, segment_area(t, last_sample_time, last_slope));
            last_sample_time = t;
            last_slope = der;
            have_slope = 1'b1;
            if (phase == PH_WAIT_SLOPE) phase = PH_RUNNING;
            else if (phase == PH_WAIT_BOTH) phase = PH_WAIT_QUANTA;
            refresh_running(t);
         end
         OP_EVENT: begin
            if (phase == PH_RUNNING) begin
               w.emitted = out_enable_reg;
               if (out_enable_reg) w.result_value = exp_value;
               last_out_value = exp_value;
               last_out_time = t;
               segment_sum = '0;
               last_sample_time = t;
               cur_value = exp_value;
               phase = PH_WAIT_QUANTA;
            end else if (phase == PH_INIT) begin
               w.emitted = out_enable_reg;
               if (out_enable_reg) w.result_value = cur_value;
               last_out_value = cur_value;
               last_out_time = t;
               phase = PH_WAIT_BOTH;
            end else begin
               w.error_code = ERR_PHASE;
            end
         end
         default: begin
            w.result_value = integrated_at(t);
            w.at_last_emission = t == last_out_time;
         end
      endcase
      // time advance
      s = have_slope ? last_slope : '0;
      if (phase == PH_RUNNING && s != 0) begin
         if (s > 0) begin
            if (upper_level < cur_value) begin
               if (w.error_code == ERR_OK) w.error_code = ERR_RISING;
            end else begin
               gap = upper_level - cur_value;
               w.time_advance = gap_over_slope(gap, slope_mag(s));
               w.advance_infinite = 1'b0;
            end
         end else begin
            if (lower_level > cur_value) begin
               if (w.error_code == ERR_OK) w.error_code = ERR_FALLING;
            end else begin
               gap = cur_value - lower_level;
               w.time_advance = gap_over_slope(gap, slope_mag(s));
               w.advance_infinite = 1'b0;
            end
         end
      end
      w.last_emitted_value = last_out_value;
   endtask

   task automatic check_field(string name, logic [VALUE_WIDTH-1:0] exp_v,
                              logic [VALUE_WIDTH-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         init_value_reg   = '0;
         out_enable_reg   = 1'b1;
         phase            = PH_INIT;
         upper_level      = '0;
         lower_level      = '0;
         cur_value        = '0;
         exp_value        = '0;
         last_out_value   = '0;
         segment_sum      = '0;
         last_slope       = '0;
         last_out_time    = '0;
         last_sample_time = '0;
         have_slope       = 1'b0;
         fail_count       = 0;
         expected_words.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_INITIAL_VALUE) begin
               init_value_reg = value_type'(csr_wdata);
               if (phase == PH_INIT) cur_value = init_value_reg;
            end else begin
               out_enable_reg = csr_wdata[0];
            end
         end
         if (req.valid && req.ready) begin
            step_integrator(req.operation, req.event_time, req.upper_threshold,
                            req.lower_threshold, req.derivative, w);
            expected_words = {expected_words, w};
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no prediction waiting");
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("emitted", w.emitted, rsp.emitted);
               check_field("result_value", w.result_value, rsp.result_value);
               check_field("last_emitted_value", w.last_emitted_value,
                           rsp.last_emitted_value);
               check_field("at_last_emission", w.at_last_emission, rsp.at_last_emission);
               check_field("time_advance", w.time_advance, rsp.time_advance);
               check_field("advance_infinite", w.advance_infinite, rsp.advance_infinite);
               check_field("error_code", w.error_code, rsp.error_code);
            end
         end
      end
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the quantized state integrator with a directed opening and random
// request words over several idle and stall settings, rewriting the
// registers between phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench import qsi_pkg::*;;

   localparam int  CYCLE_LIMIT   = 3000000;
   localparam int  DRAIN_CYCLES  = 120;
   localparam int  PHASE_ITEMS   = 300;
   localparam value_type MAX_VAL = value_type'(VMAX_U);
   localparam value_type MIN_VAL = value_type'(VMIN_U);

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic                   csr_index;
   logic [VALUE_WIDTH-1:0] csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     cycles = 0;
   int                     idle_pct;
   int                     stall_pct;
   time_type               cur_time;

   qsi_req_if req_ch ();
   qsi_rsp_if rsp_ch ();

   quantized_state_integrator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   integrator_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= $urandom_range(99) >= stall_pct;
   end

   task automatic write_reg(logic idx, logic [VALUE_WIDTH-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_word(op_type op, time_type t, value_type up, value_type lo,
                            value_type der);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.operation       <= op;
      req_ch.event_time      <= t;
      req_ch.upper_threshold <= up;
      req_ch.lower_threshold <= lo;
      req_ch.derivative      <= der;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   function automatic value_type pick_value();
      int small_v;
      small_v = int'($urandom_range(1 << 25)) - (1 << 24);
      case ($urandom_range(15))
         0: return MAX_VAL;
         1: return MIN_VAL;
         2: return '0;
         3: return value_type'({$urandom, $urandom});
         default: return value_type'(small_v);
      endcase
   endfunction

   function automatic time_type next_time(time_type t);
      case ($urandom_range(19))
         0: return time_type'({$urandom, $urandom});
         1: return t - $urandom_range(1 << 18);
         2, 3: return t;
         default: return t + $urandom_range(1 << 20);
      endcase
   endfunction

   task automatic send_random();
      op_type op;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 30) op = OP_QUANTA;
      else if (pick < 60) op = OP_SAMPLE;
      else if (pick < 85) op = OP_EVENT;
      else op = OP_OBSERVE;
      cur_time = next_time(cur_time);
      send_word(op, cur_time, pick_value(), pick_value(), pick_value());
   endtask

   task automatic settle();
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_index    = CSR_INITIAL_VALUE;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_QUANTA;
      req_ch.event_time = '0;
      req_ch.upper_threshold = '0;
      req_ch.lower_threshold = '0;
      req_ch.derivative = '0;
      idle_pct     = 0;
      stall_pct    = 0;
      cur_time     = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(CSR_INITIAL_VALUE, VMAX_U);
      write_reg(CSR_OUTPUT_ENABLED, VALUE_WIDTH'(1));
      // directed opening: init emission, wrong phase, running, extremes
      send_word(OP_OBSERVE, 48'h0, '0, '0, '0);
      send_word(OP_QUANTA, 48'h1_0000, 48'sh10_0000, -48'sh10_0000, '0);
      send_word(OP_SAMPLE, 48'h2_0000, '0, '0, 48'sh1_0000);
      send_word(OP_EVENT, 48'h3_0000, '0, '0, '0);
      send_word(OP_OBSERVE, 48'h3_0000, '0, '0, '0);
      send_word(OP_EVENT, 48'h4_0000, '0, '0, '0);
      send_word(OP_QUANTA, 48'h5_0000, MAX_VAL, MIN_VAL, '0);
      send_word(OP_SAMPLE, 48'h6_0000, '0, '0, -48'sh2_0000);
      send_word(OP_OBSERVE, 48'h8_0000, '0, '0, '0);
      send_word(OP_EVENT, 48'h9_0000, '0, '0, '0);
      send_word(OP_QUANTA, 48'ha_0000, 48'sh100_0000, -48'sh100_0000, '0);
      send_word(OP_SAMPLE, 48'hb_0000, '0, '0, '0);
      send_word(OP_EVENT, 48'hc_0000, '0, '0, '0);
      send_word(OP_SAMPLE, 48'hd_0000, '0, '0, 48'sh3_0000);
      send_word(OP_QUANTA, 48'he_0000, MIN_VAL, MIN_VAL, '0);
      send_word(OP_SAMPLE, 48'hf_0000, '0, '0, -48'sh3_0000);
      send_word(OP_QUANTA, 48'h10_0000, MAX_VAL, MAX_VAL, '0);
      // time running backwards over an open segment
      send_word(OP_OBSERVE, 48'h1, '0, '0, '0);
      send_word(OP_SAMPLE, {VALUE_WIDTH{1'b1}}, '0, '0, MIN_VAL);
      send_word(OP_OBSERVE, 48'h0, '0, '0, '0);
      send_word(OP_SAMPLE, 48'h0, '0, '0, MAX_VAL);
      send_word(OP_QUANTA, {VALUE_WIDTH{1'b1}}, 48'sh1, -48'sh1, '0);
      send_word(OP_EVENT, {VALUE_WIDTH{1'b1}}, '0, '0, '0);

      for (int ph = 0; ph < 4; ph++) begin
         req_ch.valid <= 1'b0;
         settle();
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         write_reg(CSR_INITIAL_VALUE,
                   ph[0] ? VMIN_U : VALUE_WIDTH'({$urandom, $urandom}));
         write_reg(CSR_OUTPUT_ENABLED,
                   VALUE_WIDTH'(ph == 1 ? 0 : (ph == 3 ? $urandom_range(1) : 1)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // short bursts without idling
            if ($urandom_range(49) == 0) begin
               idle_pct = 0;
               repeat (8) send_random();
               idle_pct = (ph == 1) ? 77 : ((ph == 3) ? 22 : 0);
            end
            send_random();
         end
      end
      req_ch.valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/qsi_pkg.sv
hw/rtl/qsi_if.sv
hw/rtl/qsi_divider.sv
hw/rtl/quantized_state_integrator.sv
hw/rtl/qsi_checker.sv
test/integrator_checker.sv
test/testbench.sv
